[hdl/ptsched_pkg.sv]
// ----------------------------------------------------------------------------
// ptsched_pkg
// Shared types, codes and helpers of the priority task scheduler.
// ----------------------------------------------------------------------------
package ptsched_pkg;

    localparam int TASK_COUNT_DEF = 5;
    localparam int IDX_W_MAX      = 4;
    localparam logic [7:0] PRIO_MAP_RESET = 8'd233;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_BLOCKED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SLEEP = 2'd1,
        ACT_YIELD = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_WAKE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic apply;
        logic wake;
        logic scan;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic wake_last;
        logic scan_last;
    } t_dp_sts;

    // two-bit priority of a worker; workers past the fourth get zero
    function automatic logic [1:0] worker_prio(input logic [7:0] map,
                                               input logic [IDX_W_MAX-1:0] idx);
        logic [1:0] p;
        p = 2'd0;
        if (idx < IDX_W_MAX'(4)) begin
            p = map[{idx[1:0], 1'b0} +: 2];
        end
        return p;
    endfunction

endpackage

[hdl/ptsched_ctrl.sv]
// ----------------------------------------------------------------------------
// ptsched_ctrl
// Sequencer: apply the action, sweep wake checks on a tick, scan workers, commit.
// ----------------------------------------------------------------------------
module ptsched_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ptsched_pkg::t_dp_sts i_sts,
    output ptsched_pkg::t_dp_cmd o_cmd,
    output logic                 o_busy,
    output logic                 o_valid
);

    ptsched_pkg::t_state r_state, n_state;
    logic                r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptsched_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ptsched_pkg::S_FINISH);
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ptsched_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ptsched_pkg::S_APPLY;
                end
            end
            ptsched_pkg::S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = i_sts.is_tick ? ptsched_pkg::S_WAKE : ptsched_pkg::S_SCAN;
            end
            ptsched_pkg::S_WAKE: begin
                o_cmd.wake = 1'b1;
                if (i_sts.wake_last) begin
                    n_state = ptsched_pkg::S_SCAN;
                end
            end
            ptsched_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ptsched_pkg::S_FINISH;
                end
            end
            ptsched_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ptsched_pkg::S_IDLE;
            end
            default: begin
                n_state = ptsched_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != ptsched_pkg::S_IDLE);
    assign o_valid = r_valid;

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result word shown while busy");

    a_valid_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ptsched_pkg::S_FINISH))
        else $error("result word without commit");

    a_finish_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptsched_pkg::S_FINISH) |=> o_valid)
        else $error("commit without result word");

endmodule

[hdl/ptsched_dp.sv]
// ----------------------------------------------------------------------------
// ptsched_dp
// Task table, tick counter, wake compare and round-robin priority scan.
// ----------------------------------------------------------------------------
module ptsched_dp #(
    parameter int TASK_COUNT = ptsched_pkg::TASK_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptsched_pkg::t_dp_cmd i_cmd,
    output ptsched_pkg::t_dp_sts o_sts,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_priority_map,
    input  logic [1:0]           i_action,
    input  logic [31:0]          i_sleep_ticks,
    output logic [2:0]           o_running_task,
    output logic [4:0]           o_ready_mask,
    output logic [4:0]           o_blocked_mask,
    output logic [31:0]          o_tick_value
);

    localparam int IW      = $clog2(TASK_COUNT);
    localparam int WORKERS = TASK_COUNT - 1;
    localparam logic [IW-1:0] IDLE_ID    = IW'(TASK_COUNT - 1);
    localparam logic [IW-1:0] LAST_WRK   = IW'(WORKERS - 1);
    localparam logic [IW-1:0] FIRST_IDLE = IW'(1 % WORKERS);

    logic [7:0]          r_map;
    logic [1:0]          r_action;
    logic [31:0]         r_delay;
    logic [31:0]         r_tick;
    logic [IW-1:0]       r_cur;
    ptsched_pkg::t_status r_status [TASK_COUNT];
    logic [31:0]         r_wake [TASK_COUNT];
    logic [IW-1:0]       r_widx;
    logic [IW-1:0]       r_sidx;
    logic [IW-1:0]       r_scnt;
    logic                r_found;
    logic [1:0]          r_best;
    logic [IW-1:0]       r_chosen;

    logic [IW-1:0]       scan_first;
    logic [1:0]          scan_prio;
    logic                scan_take;
    logic [TASK_COUNT-1:0] running_vec;

    // round-robin start: the worker after the running one, or worker 1 when the idle task runs
    always_comb begin
        if (r_cur == IDLE_ID) begin
            scan_first = FIRST_IDLE;
        end else if (r_cur == LAST_WRK) begin
            scan_first = '0;
        end else begin
            scan_first = r_cur + IW'(1);
        end
    end

    assign scan_prio = ptsched_pkg::worker_prio(r_map, ptsched_pkg::IDX_W_MAX'(r_sidx));
    assign scan_take = (r_status[r_sidx] == ptsched_pkg::ST_READY) &&
                       (!r_found || (scan_prio > r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= ptsched_pkg::PRIO_MAP_RESET;
            r_tick <= '0;
            r_cur  <= '0;
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_status[i] <= ptsched_pkg::ST_READY;
            end
        end else begin
            if (i_cfg_we) begin
                r_map <= i_priority_map;
            end
            if (i_cmd.apply) begin
                if (r_action == ptsched_pkg::ACT_TICK) begin
                    r_tick <= r_tick + 32'd1;
                end
                if (r_action == ptsched_pkg::ACT_SLEEP && r_cur != IDLE_ID) begin
                    r_wake[r_cur]   <= r_tick + r_delay;
                    r_status[r_cur] <= ptsched_pkg::ST_BLOCKED;
                end else if (r_status[r_cur] == ptsched_pkg::ST_RUNNING) begin
                    r_status[r_cur] <= ptsched_pkg::ST_READY;
                end
            end
            if (i_cmd.wake) begin
                if (r_status[r_widx] == ptsched_pkg::ST_BLOCKED &&
                    r_tick >= r_wake[r_widx]) begin
                    r_status[r_widx] <= ptsched_pkg::ST_READY;
                end
            end
            if (i_cmd.finish) begin
                r_cur              <= r_chosen;
                r_status[r_chosen] <= ptsched_pkg::ST_RUNNING;
            end
        end
    end

    // command latch at load; scan and sweep bookkeeping, initialized by the apply step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_delay  <= i_sleep_ticks;
        end
        if (i_cmd.apply) begin
            r_widx   <= '0;
            r_sidx   <= scan_first;
            r_scnt   <= '0;
            r_found  <= 1'b0;
            r_best   <= '0;
            r_chosen <= IDLE_ID;
        end
        if (i_cmd.wake && !o_sts.wake_last) begin
            r_widx <= r_widx + IW'(1);
        end
        if (i_cmd.scan) begin
            if (scan_take) begin
                r_found  <= 1'b1;
                r_best   <= scan_prio;
                r_chosen <= r_sidx;
            end
            r_sidx <= (r_sidx == LAST_WRK) ? '0 : r_sidx + IW'(1);
            if (!o_sts.scan_last) begin
                r_scnt <= r_scnt + IW'(1);
            end
        end
    end

    assign o_sts.is_tick   = (r_action == ptsched_pkg::ACT_TICK);
    assign o_sts.wake_last = (r_widx == IDLE_ID);
    assign o_sts.scan_last = (r_scnt == LAST_WRK);

    for (genvar g = 0; g < 5; g++) begin : g_mask
        if (g < TASK_COUNT) begin : g_on
            assign o_ready_mask[g]   = (r_status[g] == ptsched_pkg::ST_READY);
            assign o_blocked_mask[g] = (r_status[g] == ptsched_pkg::ST_BLOCKED);
        end else begin : g_off
            assign o_ready_mask[g]   = 1'b0;
            assign o_blocked_mask[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < TASK_COUNT; g++) begin : g_run
        assign running_vec[g] = (r_status[g] == ptsched_pkg::ST_RUNNING);
    end

    assign o_running_task = 3'(r_cur);
    assign o_tick_value   = r_tick;

    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(running_vec))
        else $error("more than one task running");

    a_idle_awake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status[IDLE_ID] != ptsched_pkg::ST_BLOCKED)
        else $error("idle task blocked");

    a_commit_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_status[r_cur] == ptsched_pkg::ST_RUNNING))
        else $error("selected task not running");

endmodule

[hdl/priority_task_scheduler.sv]
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Selects the running task among four workers and an idle task on tick,
// sleep and yield commands, by priority with round-robin tie order.
// ----------------------------------------------------------------------------
//  channel   handshake                    word
//  command   start, busy                  i_action, i_sleep_ticks
//  result    o_valid (one-cycle strobe)   o_running_task, o_ready_mask,
//                                         o_blocked_mask, o_tick_value
//  config    i_cfg_valid, o_cfg_ready     i_priority_map
//
//  A command applies its action, sweeps one wake compare per task entry on a
//  tick only, scans the workers and commits; the result strobe follows the
//  commit in the next cycle, in which a new command may already be taken.
//  The scan walks one worker per cycle through a single priority compare.
//  Synchronous active-low reset: all tasks ready, task0 current, tick zero.
//  Results cannot be stalled; config is taken whenever the block is idle.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
    parameter int TASK_COUNT = ptsched_pkg::TASK_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_sleep_ticks,
    output logic        o_valid,
    output logic [2:0]  o_running_task,
    output logic [4:0]  o_ready_mask,
    output logic [4:0]  o_blocked_mask,
    output logic [31:0] o_tick_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_priority_map
);

    ptsched_pkg::t_dp_cmd cmd;
    ptsched_pkg::t_dp_sts sts;

    assign o_cfg_ready = !busy;

    ptsched_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ptsched_dp #(
        .TASK_COUNT (TASK_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_priority_map (i_priority_map),
        .i_action       (i_action),
        .i_sleep_ticks  (i_sleep_ticks),
        .o_running_task (o_running_task),
        .o_ready_mask   (o_ready_mask),
        .o_blocked_mask (o_blocked_mask),
        .o_tick_value   (o_tick_value)
    );

endmodule

[sim/tb_priority_task_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler
// Self-checking bench for the priority task scheduler: an internal task
// model predicts the running task, ready and blocked masks and tick count
// for every accepted command word, under several priority maps and with
// random command bursts, gaps and drain pauses.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TASK_N    = 5;
    localparam int          WORKERS   = TASK_N - 1;
    localparam int unsigned IDLE_ID   = TASK_N - 1;
    localparam logic [1:0]  ACT_SPARE = 2'd3;    // undefined code, acts as yield
    localparam int          N_PHASES  = 8;
    localparam int          PHASE_LEN = 117;

    typedef struct packed {
        logic [2:0]  run_id;
        logic [4:0]  ready;
        logic [4:0]  blocked;
        logic [31:0] ticks;
    } t_status_word;

    // ------------------------------------------------------------------------
    // task model and result checker
    // ------------------------------------------------------------------------
    class sched_scoreboard;
        logic [7:0]           prio_map;
        ptsched_pkg::t_status status[TASK_N];
        logic [31:0]          wake_at[TASK_N];
        logic [31:0]          ticks;
        int unsigned          slot;
        t_status_word         expected_q[$];
        int unsigned          n_bad, n_words, n_ticks, n_sleeps, n_yields, n_idle;
        int unsigned          n_wakes, n_maps;

        function new();
            prio_map = ptsched_pkg::PRIO_MAP_RESET;
            for (int i = 0; i < TASK_N; i++) begin
                status[i]  = ptsched_pkg::ST_READY;
                wake_at[i] = '0;
            end
            ticks = '0;
            slot  = 0;
        endfunction

        function void set_map(logic [7:0] map);
            prio_map = map;
            n_maps++;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_command(logic [1:0] act, logic [31:0] delay);
            t_status_word w;
            int unsigned  cur;
            int unsigned  idx;
            int unsigned  pick;
            logic         found;
            logic [1:0]   best;
            logic [1:0]   p;
            cur = slot;
            if (act == ptsched_pkg::ACT_TICK) begin
                n_ticks++;
                ticks = ticks + 32'd1;
                for (int i = 0; i < TASK_N; i++) begin
                    if (status[i] == ptsched_pkg::ST_BLOCKED && ticks >= wake_at[i]) begin
                        status[i] = ptsched_pkg::ST_READY;
                        n_wakes++;
                    end
                end
            end else if (act == ptsched_pkg::ACT_SLEEP) begin
                n_sleeps++;
                if (cur != IDLE_ID) begin
                    wake_at[cur] = ticks + delay;
                    status[cur]  = ptsched_pkg::ST_BLOCKED;
                end
            end else begin
                n_yields++;
            end
            // return the running task, then scan workers from the one after it
            if (status[cur] == ptsched_pkg::ST_RUNNING)
                status[cur] = ptsched_pkg::ST_READY;
            found = 1'b0;
            best  = '0;
            pick  = IDLE_ID;
            for (int k = 1; k <= WORKERS; k++) begin
                idx = (cur + k) % WORKERS;
                if (status[idx] == ptsched_pkg::ST_READY) begin
                    p = prio_map[2*idx +: 2];
                    if (!found || p > best) begin
                        found = 1'b1;
                        best  = p;
                        pick  = idx;
                    end
                end
            end
            slot         = pick;
            status[pick] = ptsched_pkg::ST_RUNNING;
            if (pick == IDLE_ID)
                n_idle++;
            w.run_id  = 3'(pick);
            w.ready   = '0;
            w.blocked = '0;
            for (int i = 0; i < TASK_N; i++) begin
                w.ready[i]   = (status[i] == ptsched_pkg::ST_READY);
                w.blocked[i] = (status[i] == ptsched_pkg::ST_BLOCKED);
            end
            w.ticks = ticks;
            expected_q.push_back(w);
        endfunction

        function void check_result(t_status_word got);
            t_status_word want;
            logic         bad;
            if (expected_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display({"%t: unexpected result word run=%0d ready=%b ",
                              "blocked=%b tick=%0d"},
                             $realtime, got.run_id, got.ready, got.blocked, got.ticks);
                return;
            end
            want = expected_q.pop_front();
            n_words++;
            bad = 1'b0;
            if (got.run_id  !== want.run_id)  bad = 1'b1;
            if (got.ready   !== want.ready)   bad = 1'b1;
            if (got.blocked !== want.blocked) bad = 1'b1;
            if (got.ticks   !== want.ticks)   bad = 1'b1;
            if (bad) begin
                n_bad++;
                if (n_bad <= 10)
                    $display({"%t: word %0d mismatch: run %0d/%0d ready %b/%b ",
                              "blocked %b/%b tick %0d/%0d (exp/act)"},
                             $realtime, n_words, want.run_id, got.run_id,
                             want.ready, got.ready, want.blocked, got.blocked,
                             want.ticks, got.ticks);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic [1:0]  i_action       = ptsched_pkg::ACT_YIELD;
    logic [31:0] i_sleep_ticks  = '0;
    logic        i_cfg_valid    = 1'b0;
    logic [7:0]  i_priority_map = ptsched_pkg::PRIO_MAP_RESET;
    logic        busy;
    logic        o_valid;
    logic [2:0]  o_running_task;
    logic [4:0]  o_ready_mask;
    logic [4:0]  o_blocked_mask;
    logic [31:0] o_tick_value;
    logic        o_cfg_ready;

    sched_scoreboard sb = new();

    always #2 i_clk = ~i_clk;

    priority_task_scheduler #(
        .TASK_COUNT (TASK_N)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_sleep_ticks  (i_sleep_ticks),
        .o_valid        (o_valid),
        .o_running_task (o_running_task),
        .o_ready_mask   (o_ready_mask),
        .o_blocked_mask (o_blocked_mask),
        .o_tick_value   (o_tick_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_priority_map (i_priority_map)
    );

    // sample every handshake at the edge that completes it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result({o_running_task, o_ready_mask, o_blocked_mask,
                                 o_tick_value});
            if (start && !busy)
                sb.note_command(i_action, i_sleep_ticks);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_map(i_priority_map);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_cmd(input logic [1:0] act, input logic [31:0] delay);
        start         <= 1'b1;
        i_action      <= act;
        i_sleep_ticks <= delay;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 14);
        start         <= 1'b0;
        i_action      <= 2'($urandom);
        i_sleep_ticks <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || busy)
            @(posedge i_clk);
    endtask

    task automatic write_map(input logic [7:0] map);
        drain();
        i_cfg_valid    <= 1'b1;
        i_priority_map <= map;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
    endtask

    // mostly short delays so tasks come back; some wrap past 2^32 and wake early
    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15 && sb.ticks > 1)
            return 32'hFFFF_FFFF - $urandom_range(0, sb.ticks - 1);
        else if (r < 35)
            return $urandom_range(0, 3);
        return $urandom_range(0, 12);
    endfunction

    task automatic random_cmds(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int          r;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < count) begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    send_cmd(ptsched_pkg::ACT_TICK, $urandom);
                else if (r < 75)
                    send_cmd(ptsched_pkg::ACT_SLEEP, pick_delay());
                else if (r < 95)
                    send_cmd(ptsched_pkg::ACT_YIELD, $urandom);
                else
                    send_cmd(ACT_SPARE, $urandom);
                burst--;
                sent++;
            end
            if ($urandom_range(0, 39) == 0)
                drain();
            else
                idle_gap();
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] map;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset priorities, wrap wake, all workers asleep, idle sleep
        send_cmd(ptsched_pkg::ACT_YIELD, 32'h0);
        send_cmd(ACT_SPARE, 32'hFFFF_FFFF);
        send_cmd(ptsched_pkg::ACT_TICK, 32'hFFFF_FFFF);
        send_cmd(ptsched_pkg::ACT_SLEEP, 32'h0);
        send_cmd(ptsched_pkg::ACT_TICK, 32'h0);
        send_cmd(ptsched_pkg::ACT_SLEEP, 32'hFFFF_FFFF);
        send_cmd(ptsched_pkg::ACT_TICK, 32'hA5A5_5A5A);
        send_cmd(ptsched_pkg::ACT_SLEEP, 32'd2);
        send_cmd(ptsched_pkg::ACT_SLEEP, 32'd3);
        send_cmd(ptsched_pkg::ACT_SLEEP, 32'd5);
        send_cmd(ptsched_pkg::ACT_SLEEP, 32'd1);
        send_cmd(ptsched_pkg::ACT_SLEEP, 32'd7);
        send_cmd(ptsched_pkg::ACT_YIELD, 32'h5A5A_A5A5);
        idle_gap();
        repeat (6) send_cmd(ptsched_pkg::ACT_TICK, 32'h0);
        send_cmd(ptsched_pkg::ACT_SLEEP, 32'h0);
        send_cmd(ptsched_pkg::ACT_YIELD, 32'h0);
        send_cmd(ACT_SPARE, 32'h0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: map = 8'h00;
                1: map = 8'hFF;
                2: map = 8'h1B;
                3: map = 8'hE4;
                default: map = 8'($urandom);
            endcase
            write_map(map);
            random_cmds(PHASE_LEN);
        end

        // far wake times that never come within the run
        send_cmd(ptsched_pkg::ACT_SLEEP, $urandom);
        send_cmd(ptsched_pkg::ACT_SLEEP, $urandom | 32'h8000_0000);
        repeat (4) send_cmd(ptsched_pkg::ACT_TICK, 32'h0);
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d commands (%0d ticks, %0d sleeps, %0d yields), %0d wakeups",
                 sb.n_ticks + sb.n_sleeps + sb.n_yields, sb.n_ticks, sb.n_sleeps,
                 sb.n_yields, sb.n_wakes);
        $display("idle picked %0d times, %0d priority maps written, %0d words checked",
                 sb.n_idle, sb.n_maps, sb.n_words);
        if (sb.n_bad == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d bad words, %0d expected words missing", sb.n_bad, sb.pending());
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d expected words pending", sb.pending());
        $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hdl/ptsched_pkg.sv
hdl/ptsched_ctrl.sv
hdl/ptsched_dp.sv
hdl/priority_task_scheduler.sv
sim/tb_priority_task_scheduler.sv
